[rtl/ppc_pkg.sv]
// Package for the pedal position conditioner.
// Holds widths, reset values, filter constants, the controller state type and the
// command and status structs that pass between the controller and the datapath.
package ppc_pkg;

  localparam int NUM_PEDALS = 3;
  localparam int NUM_REGS   = 6;
  localparam int SEL_W      = 2;
  localparam int MV_W       = 12;
  localparam int VAL_W      = 8;
  localparam int SMOOTH_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int PED_IDX_W  = $clog2(NUM_PEDALS);

  localparam logic [MV_W-1:0] LOW_RESET  = 12'd1000;
  localparam logic [MV_W-1:0] HIGH_RESET = 12'd3200;

  // floor(x / 20) == (x * RECIP20) >> 16 for every x up to 4114.
  localparam logic [11:0] RECIP20    = 12'd3277;
  localparam logic [4:0]  ROUND_UP20 = 5'd19;

  localparam int SLEW_MAX    = 12;
  localparam int DELTA_LIMIT = 15 * 256;
  localparam logic [8:0] ALPHA_FAST = 9'd179;
  localparam logic [8:0] ALPHA_SLOW = 9'd51;

  localparam int DIV_STEPS = VAL_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef logic [PED_IDX_W-1:0] ped_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEAD,
    S_RANGE,
    S_DIV,
    S_SMOOTH,
    S_COMMIT
  } ppc_state_t;

  typedef struct packed {
    logic load;
    logic dead;
    logic range;
    logic div_step;
    logic smooth;
    logic commit;
  } ppc_cmd_t;

  typedef struct packed {
    logic sel_bad;
    logic out_free;
  } ppc_status_t;

endpackage

[rtl/ppc_if.sv]
// Request channel interfaces of the pedal position conditioner.
// Depends on ppc_pkg for the field widths.
interface ppc_sample_if import ppc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] pedal_sel;
  logic [MV_W-1:0]  sample_mv;

  modport source (output valid, output pedal_sel, output sample_mv, input ready);
  modport sink (input valid, input pedal_sel, input sample_mv, output ready);
endinterface

interface ppc_result_if import ppc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] pedal_out;
  logic [VAL_W-1:0] pedal_value;

  modport source (output valid, output pedal_out, output pedal_value, input ready);
  modport sink (input valid, input pedal_out, input pedal_value, output ready);
endinterface

[rtl/pedal_position_conditioner.sv]
// Top level of the pedal position conditioner.
// Depends on ppc_pkg, the channel interfaces in ppc_if, ppc_ctrl and ppc_datapath.
//
// Each request carries a millivolt sample for one of three pedals (0 sustain,
// 1 sostenuto, 2 soft) and yields exactly one result with the pedal index and a
// conditioned position from 0 (released) to 255 (pressed). The calibrated range of
// the pedal is narrowed by a 5% dead zone at each end, the sample is clamped into
// it and scaled to 0..255, then passed through an adaptive exponential average
// (fast when the step exceeds 15 counts) and a slew limiter of 12 counts per request.
// A pedal whose narrowed range is empty or inverted reads as 0 before smoothing.
// A pedal index of 3 returns value 0 and leaves all state unchanged. Calibration is
// written through cfg_we, cfg_index and cfg_data (indexes 0..5: low then high of
// each pedal, reset 1000 mV and 3200 mV); writes to indexes 6 and 7 are dropped,
// and writes are expected only while no request is in flight. After a valid
// request is accepted, the next one is accepted only once the first has passed
// the dead zone and range steps, the bit-serial divide that scales the clamped
// sample, and the smooth and commit steps; an out-of-range pedal index skips
// the range, divide and smooth steps. The last step waits while an earlier
// result still sits unclaimed in the result register, which stretches the gap
// by the time the receiver holds off. The result register frees the input side, so
// a new request may be accepted while the previous result still waits to be taken.
module pedal_position_conditioner import ppc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data,
  ppc_sample_if.sink           sample_ch,
  ppc_result_if.source         result_ch
);

  ppc_cmd_t    cmd;
  ppc_status_t st;

  // The controller sequences dead zone, range, divide, smooth and commit steps.
  ppc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the calibration, the per-pedal filter state and the result.
  ppc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .st          (st),
    .pedal_sel   (sample_ch.pedal_sel),
    .sample_mv   (sample_ch.sample_mv),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .pedal_out   (result_ch.pedal_out),
    .pedal_value (result_ch.pedal_value)
  );

  // An accepted request always starts with the dead zone step.
  a_load_then_dead: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready) |=> cmd.dead)
    else $error("accepted request did not enter the dead zone step");

  // The controller issues at most one command per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.dead, cmd.range, cmd.div_step, cmd.smooth, cmd.commit}))
    else $error("more than one datapath command in a cycle");

  // A result is only written when the result register can take it.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> st.out_free)
    else $error("commit while the result register is still occupied");

  // A commit always presents a result in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_ch.valid)
    else $error("commit did not produce a valid result");

endmodule

[rtl/ppc_ctrl.sv]
// Controller state machine of the pedal position conditioner.
// Depends on ppc_pkg; drives the datapath through ppc_cmd_t.
module ppc_ctrl import ppc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ppc_status_t st,
  output ppc_cmd_t    cmd
);

  ppc_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DEAD;
      end
      S_DEAD: begin
        state_next = st.sel_bad ? S_COMMIT : S_RANGE;
      end
      S_RANGE: begin
        state_next = S_DIV;
        cnt_next   = '0;
      end
      S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = S_SMOOTH;
      end
      S_SMOOTH: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DEAD:   cmd.dead     = 1'b1;
      S_RANGE:  cmd.range    = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_SMOOTH: cmd.smooth   = 1'b1;
      S_COMMIT: cmd.commit   = st.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/ppc_datapath.sv]
// Datapath of the pedal position conditioner: calibration registers, dead zone,
// serial divider, adaptive smoothing, slew limiter, per-pedal state and result register.
// Depends on ppc_pkg; steered by ppc_ctrl through ppc_cmd_t.
module ppc_datapath import ppc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data,
  input  ppc_cmd_t             cmd,
  output ppc_status_t          st,
  input  logic [SEL_W-1:0]     pedal_sel,
  input  logic [MV_W-1:0]      sample_mv,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SEL_W-1:0]     pedal_out,
  output logic [VAL_W-1:0]     pedal_value
);

  logic [MV_W-1:0]     cal_low  [NUM_PEDALS];
  logic [MV_W-1:0]     cal_high [NUM_PEDALS];
  logic [SMOOTH_W-1:0] smooth   [NUM_PEDALS];
  logic [VAL_W-1:0]    prev     [NUM_PEDALS];

  logic [SEL_W-1:0]  sel;
  logic [MV_W-1:0]   sample;
  logic              sel_bad;
  logic              span_neg;
  logic [7:0]        fl, cl;
  logic              wpos;
  logic [MV_W-1:0]   rem;
  logic [VAL_W-1:0]  num_lo;
  logic [MV_W-1:0]   divisor;
  logic [VAL_W-1:0]  quot;
  logic signed [25:0] prod;

  ped_idx_t          pidx;
  ped_idx_t          cfg_ped;
  logic [MV_W-1:0]   low_c, high_c;

  // Dead zone margins.
  logic [MV_W-1:0]   span_abs;
  logic [12:0]       span_up;
  logic [23:0]       fl_prod;
  logic [24:0]       cl_prod;

  // Narrowed range, clamp and numerator.
  logic signed [13:0] lo_s, hi_s, width_s;
  logic               wpos_c;
  logic [MV_W-1:0]    lo12, hi12, clamped, offset;
  logic [19:0]        num;

  // Divider step.
  logic [12:0]        trial;
  logic               qbit;

  // Smoothing and slew limiting.
  logic [VAL_W-1:0]   raw;
  logic signed [17:0] delta;
  logic signed [9:0]  alpha_s;
  logic signed [17:0] inc;
  logic signed [18:0] sm_sum;
  logic [SMOOTH_W-1:0] sm_new;
  logic [VAL_W-1:0]   level;
  logic signed [8:0]  diff;
  logic [VAL_W-1:0]   pv_new;

  assign pidx    = sel[PED_IDX_W-1:0];
  assign cfg_ped = cfg_index[PED_IDX_W:1];
  assign low_c   = cal_low[pidx];
  assign high_c  = cal_high[pidx];

  always_comb begin
    span_abs = (high_c >= low_c) ? (high_c - low_c) : (low_c - high_c);
    span_up  = {1'b0, span_abs} + 13'(ROUND_UP20);
    fl_prod  = span_abs * RECIP20;
    cl_prod  = span_up * RECIP20;
  end

  always_comb begin
    if (span_neg) begin
      lo_s = $signed({2'b00, low_c})  - $signed({6'd0, cl});
      hi_s = $signed({2'b00, high_c}) + $signed({6'd0, fl});
    end else begin
      lo_s = $signed({2'b00, low_c})  + $signed({6'd0, fl});
      hi_s = $signed({2'b00, high_c}) - $signed({6'd0, cl});
    end
    width_s = hi_s - lo_s;
    wpos_c  = !span_neg && (width_s > 14'sd0);
    lo12    = lo_s[MV_W-1:0];
    hi12    = hi_s[MV_W-1:0];
    if (sample < lo12)      clamped = lo12;
    else if (sample > hi12) clamped = hi12;
    else                    clamped = sample;
    offset = clamped - lo12;
    num    = {offset, 8'd0} - {8'd0, offset};
  end

  always_comb begin
    trial = {rem, num_lo[VAL_W-1]};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_comb begin
    raw     = wpos ? quot : '0;
    delta   = $signed({2'b00, raw, 8'd0}) - $signed({2'b00, smooth[pidx]});
    alpha_s = ((delta > $signed(18'(DELTA_LIMIT))) || (delta < -$signed(18'(DELTA_LIMIT))))
              ? $signed({1'b0, ALPHA_FAST}) : $signed({1'b0, ALPHA_SLOW});
  end

  always_comb begin
    inc    = prod[25:8];
    sm_sum = $signed({3'b000, smooth[pidx]}) + $signed({inc[17], inc});
    if (sm_sum[18])             sm_new = '0;
    else if (|sm_sum[17:16])    sm_new = '1;
    else                        sm_new = sm_sum[SMOOTH_W-1:0];
    level = sm_new[SMOOTH_W-1:SMOOTH_W-VAL_W];
    diff  = $signed({1'b0, level}) - $signed({1'b0, prev[pidx]});
    if (diff > $signed(9'(SLEW_MAX)))       pv_new = prev[pidx] + VAL_W'(SLEW_MAX);
    else if (diff < -$signed(9'(SLEW_MAX))) pv_new = prev[pidx] - VAL_W'(SLEW_MAX);
    else                                    pv_new = level;
  end

  // Working registers of one request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel     <= pedal_sel;
      sample  <= sample_mv;
      sel_bad <= (pedal_sel >= SEL_W'(NUM_PEDALS));
    end
    if (cmd.dead) begin
      span_neg <= (high_c < low_c);
      fl       <= fl_prod[23:16];
      cl       <= cl_prod[23:16];
    end
    if (cmd.range) begin
      wpos    <= wpos_c;
      rem     <= num[19:8];
      num_lo  <= num[7:0];
      divisor <= width_s[MV_W-1:0];
      quot    <= '0;
    end
    if (cmd.div_step) begin
      rem    <= qbit ? (trial[MV_W-1:0] - divisor) : trial[MV_W-1:0];
      num_lo <= {num_lo[VAL_W-2:0], 1'b0};
      quot   <= {quot[VAL_W-2:0], qbit};
    end
    if (cmd.smooth) begin
      prod <= 26'(alpha_s * delta);
    end
  end

  // Calibration and per-pedal filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PEDALS; i++) begin
        cal_low[i]  <= LOW_RESET;
        cal_high[i] <= HIGH_RESET;
        smooth[i]   <= '0;
        prev[i]     <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
        if (cfg_index[0]) cal_high[cfg_ped] <= cfg_data;
        else              cal_low[cfg_ped]  <= cfg_data;
      end
      if (cmd.commit && !sel_bad) begin
        smooth[pidx] <= sm_new;
        prev[pidx]   <= pv_new;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pedal_out   <= sel;
      pedal_value <= sel_bad ? '0 : pv_new;
    end
  end

  assign st.sel_bad  = sel_bad;
  assign st.out_free = !out_valid || out_ready;

endmodule

[tb/pedal_position_conditioner_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for pedal_position_conditioner: directed table, then random phases.
// Depends on ppc_pkg and the channel interfaces in ppc_if; reads no files.
module pedal_position_conditioner_tb;
  import ppc_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int IDLE_PCT        = 37;
  // Extra wait after the last result, before touching the calibration registers
  // or ending the run.
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 7;
  localparam int PHASE_REQUESTS  = 200;
  localparam int MAX_REPORTS     = 40;
  localparam int MV_MAX          = (1 << MV_W) - 1;
  localparam int NO_CHECK        = -1;

  // Pedal codes as they travel on pedal_sel and pedal_out: the right pedal is
  // the sustain, the middle one the sostenuto and the left one the soft pedal.
  localparam logic [SEL_W-1:0] PEDAL_RIGHT  = 2'd0;
  localparam logic [SEL_W-1:0] PEDAL_MIDDLE = 2'd1;
  localparam logic [SEL_W-1:0] PEDAL_LEFT   = 2'd2;
  localparam logic [SEL_W-1:0] PEDAL_NONE   = 2'd3;

  // Calibration register map; the two top indexes are not backed by a register.
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOSTENUTO_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOSTENUTO_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_LO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_HI      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7       = 3'd7;

  localparam logic [CFG_IDX_W-1:0] LOW_REG [NUM_PEDALS] =
    '{REG_SUSTAIN_LO, REG_SOSTENUTO_LO, REG_SOFT_LO};
  localparam logic [CFG_IDX_W-1:0] HIGH_REG [NUM_PEDALS] =
    '{REG_SUSTAIN_HI, REG_SOSTENUTO_HI, REG_SOFT_HI};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One row of the directed table. For a request, code is the pedal and value
  // the sample; for a register write, code is the index and value the data.
  // A want of NO_CHECK leaves the expected position to the predictor.
  typedef struct {
    row_kind_t kind;
    int        code;
    int        value;
    int        want;
  } dir_row_t;

  typedef struct packed {
    logic [SEL_W-1:0] pedal;
    logic [VAL_W-1:0] position;
  } pedal_result_t;

  localparam int DIRECTED_ROWS = 27;

  // The typed expectations follow straight from the reset calibration
  // (1000 mV to 3200 mV, narrowed to 1110..3090): a full press from rest
  // jumps the average to 178 but the slew limit lets out only 12; a released
  // pedal at rest stays at 0; the unused pedal code always reads 0; and an
  // inverted range on a pedal at rest reads 0.
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_REQ, PEDAL_RIGHT,        MV_MAX, 12},
    '{ROW_REQ, PEDAL_MIDDLE,       0,      0},
    '{ROW_REQ, PEDAL_NONE,         MV_MAX, 0},
    '{ROW_REQ, PEDAL_NONE,         0,      0},
    '{ROW_REQ, PEDAL_LEFT,         2000,   NO_CHECK},
    '{ROW_REQ, PEDAL_RIGHT,        MV_MAX, NO_CHECK},
    '{ROW_REQ, PEDAL_RIGHT,        MV_MAX, NO_CHECK},
    '{ROW_REQ, PEDAL_RIGHT,        0,      NO_CHECK},
    '{ROW_REQ, PEDAL_LEFT,         2040,   NO_CHECK},
    '{ROW_CFG, REG_SUSTAIN_LO,     0,      NO_CHECK},
    '{ROW_CFG, REG_SUSTAIN_HI,     MV_MAX, NO_CHECK},
    '{ROW_REQ, PEDAL_RIGHT,        MV_MAX, NO_CHECK},
    '{ROW_REQ, PEDAL_RIGHT,        2048,   NO_CHECK},
    '{ROW_CFG, REG_SOSTENUTO_LO,   3000,   NO_CHECK},
    '{ROW_CFG, REG_SOSTENUTO_HI,   1000,   NO_CHECK},
    '{ROW_REQ, PEDAL_MIDDLE,       MV_MAX, 0},
    '{ROW_CFG, REG_SOFT_LO,        2000,   NO_CHECK},
    '{ROW_CFG, REG_SOFT_HI,        2000,   NO_CHECK},
    '{ROW_REQ, PEDAL_LEFT,         2000,   NO_CHECK},
    '{ROW_CFG, REG_SOFT_HI,        2019,   NO_CHECK},
    '{ROW_REQ, PEDAL_LEFT,         2010,   NO_CHECK},
    '{ROW_CFG, REG_SPARE6,         MV_MAX, NO_CHECK},
    '{ROW_CFG, REG_SPARE7,         0,      NO_CHECK},
    '{ROW_REQ, PEDAL_MIDDLE,       0,      NO_CHECK},
    '{ROW_CFG, REG_SOSTENUTO_LO,   MV_MAX, NO_CHECK},
    '{ROW_CFG, REG_SOSTENUTO_HI,   0,      NO_CHECK},
    '{ROW_REQ, PEDAL_MIDDLE,       2048,   NO_CHECK}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MV_W-1:0]      cfg_data;

  ppc_sample_if sample_ch ();
  ppc_result_if result_ch ();

  pedal_position_conditioner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // Shadow of the block: calibration registers plus the per-pedal average and
  // last output position.
  logic [MV_W-1:0]     cal_lo_mv [NUM_PEDALS];
  logic [MV_W-1:0]     cal_hi_mv [NUM_PEDALS];
  logic [SMOOTH_W-1:0] avg_q88   [NUM_PEDALS];
  logic [VAL_W-1:0]    last_pos  [NUM_PEDALS];

  // Expected results in request order.
  pedal_result_t pending_positions [$];

  // Random walk of each pedal's voltage, so that most random requests look
  // like a foot moving the pedal rather than noise.
  int glide_mv [NUM_PEDALS];

  logic idle_on      = 1'b1;
  logic hold_request = 1'b0;
  logic hold_off     = 1'b0;

  int error_count     = 0;
  int results_checked = 0;
  int requests_sent   = 0;

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Division that rounds toward minus infinity, as the block does everywhere.
  function automatic int floor_div(input int x, input int d);
    return (x >= 0) ? x / d : -((-x + d - 1) / d);
  endfunction

  // Works out the position the block returns for one request and advances the
  // shadow state of that pedal. The unused pedal code reads 0 and changes nothing.
  function automatic logic [VAL_W-1:0] condition_sample(input logic [SEL_W-1:0] sel,
                                                        input logic [MV_W-1:0] mv);
    int span;
    int lo;
    int hi;
    int width;
    int clamped;
    int raw;
    int delta;
    int alpha;
    int sm;
    int level;
    int step;
    int pos;
    if (int'(sel) >= NUM_PEDALS)
      return '0;
    // Narrow the calibrated range by 5% at each end: the low edge rounds
    // down and the high edge rounds its cut up.
    span  = int'(cal_hi_mv[sel]) - int'(cal_lo_mv[sel]);
    lo    = int'(cal_lo_mv[sel]) + floor_div(span, 20);
    hi    = int'(cal_hi_mv[sel]) + floor_div(-span, 20);
    width = hi - lo;
    // An empty or inverted range reads as released, but still feeds the filter.
    raw = 0;
    if (width > 0) begin
      clamped = int'(mv);
      if (clamped < lo)
        clamped = lo;
      if (clamped > hi)
        clamped = hi;
      raw = (255 * (clamped - lo)) / width;
      if (raw > 255)
        raw = 255;
    end
    // Adaptive average in Q8.8: fast when the jump exceeds 15 counts.
    sm    = int'(avg_q88[sel]);
    delta = raw * 256 - sm;
    alpha = (delta > DELTA_LIMIT || delta < -DELTA_LIMIT) ? int'(ALPHA_FAST)
                                                          : int'(ALPHA_SLOW);
    sm += floor_div(alpha * delta, 256);
    if (sm < 0)
      sm = 0;
    if (sm > 65535)
      sm = 65535;
    avg_q88[sel] = sm[SMOOTH_W-1:0];
    // Slew limit against the last position of this pedal.
    level = sm >>> 8;
    if (level > 255)
      level = 255;
    step = level - int'(last_pos[sel]);
    if (step > SLEW_MAX)
      step = SLEW_MAX;
    if (step < -SLEW_MAX)
      step = -SLEW_MAX;
    pos = int'(last_pos[sel]) + step;
    if (pos < 0)
      pos = 0;
    if (pos > 255)
      pos = 255;
    last_pos[sel] = pos[VAL_W-1:0];
    return pos[VAL_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_REPORTS)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Offers one request, possibly after a random idle gap, and records the
  // expected result at the edge where it is accepted. Called and returning at
  // a falling edge. Valid is only lowered inside the gap, so back-to-back
  // requests keep it high without a glitch.
  task automatic send_request(input logic [SEL_W-1:0] sel, input logic [MV_W-1:0] mv,
                              input int want);
    pedal_result_t exp_res;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.pedal_sel <= sel;
    sample_ch.sample_mv <= mv;
    @(posedge clk);
    while (!sample_ch.ready)
      @(posedge clk);
    exp_res.pedal    = sel;
    exp_res.position = condition_sample(sel, mv);
    if (want != NO_CHECK)
      exp_res.position = VAL_W'(want);
    pending_positions.push_back(exp_res);
    requests_sent++;
    @(negedge clk);
  endtask

  // Drops valid and waits until every result is back and the block has had
  // time to go idle.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (pending_positions.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write, mirrored into the shadow calibration. Writes to the
  // indexes past the map are dropped by the block and here alike.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (int'(idx) < NUM_REGS) begin
      if (idx[0])
        cal_hi_mv[idx[CFG_IDX_W-1:1]] = data;
      else
        cal_lo_mv[idx[CFG_IDX_W-1:1]] = data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // New calibration for a random phase. The first phase restores the reset
  // values, the second opens every pedal to the full scale, the rest mix wide
  // ranges with empty, inverted, very narrow and full-scale ones.
  task automatic program_calibration(input int phase);
    int k;
    int lo;
    int hi;
    for (k = 0; k < NUM_PEDALS; k++) begin
      if (phase == 0) begin
        lo = int'(LOW_RESET);
        hi = int'(HIGH_RESET);
      end else if (phase == 1) begin
        lo = 0;
        hi = MV_MAX;
      end else begin
        case ($urandom_range(0, 11))
          0: begin
            lo = $urandom_range(0, MV_MAX);
            hi = lo;
          end
          1: begin
            lo = $urandom_range(2048, MV_MAX);
            hi = $urandom_range(0, 2047);
          end
          2: begin
            lo = $urandom_range(0, 4000);
            hi = lo + int'($urandom_range(0, 60));
            if (hi > MV_MAX)
              hi = MV_MAX;
          end
          3: begin
            lo = 0;
            hi = MV_MAX;
          end
          default: begin
            lo = $urandom_range(0, 1800);
            hi = $urandom_range(2300, MV_MAX);
          end
        endcase
      end
      write_reg(LOW_REG[k], MV_W'(lo));
      write_reg(HIGH_REG[k], MV_W'(hi));
      glide_mv[k] = (lo + hi) / 2;
    end
    write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, MV_W'($urandom_range(0, MV_MAX)));
  endtask

  // Sample voltage for a random request: mostly a pedal gliding or being
  // pressed and released, with full-range noise, rail values and values
  // around the edges of the calibrated range mixed in.
  function automatic logic [MV_W-1:0] pick_sample(input logic [SEL_W-1:0] sel);
    int ped;
    int mv;
    ped = (int'(sel) < NUM_PEDALS) ? int'(sel) : 0;
    case ($urandom_range(0, 9))
      0, 1, 2: mv = $urandom_range(0, MV_MAX);
      3:       mv = $urandom_range(0, 1) ? MV_MAX : 0;
      4: begin
        mv = $urandom_range(0, 1) ? int'(cal_lo_mv[ped]) : int'(cal_hi_mv[ped]);
        mv = mv + int'($urandom_range(0, 250)) - 125;
      end
      default: begin
        if ($urandom_range(0, 15) == 0)
          glide_mv[ped] = $urandom_range(0, MV_MAX);
        else
          glide_mv[ped] = glide_mv[ped] + int'($urandom_range(0, 60)) - 30;
        if (glide_mv[ped] < 0)
          glide_mv[ped] = 0;
        if (glide_mv[ped] > MV_MAX)
          glide_mv[ped] = MV_MAX;
        mv = glide_mv[ped];
      end
    endcase
    if (mv < 0)
      mv = 0;
    if (mv > MV_MAX)
      mv = MV_MAX;
    return MV_W'(mv);
  endfunction

  // Receiver: ready changes at the falling edge, idling at random unless a
  // long hold-off is under way.
  always @(negedge clk) begin
    if (hold_off)
      result_ch.ready <= 1'b0;
    else
      result_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
  end

  // Long hold-off on the result side, counted here so that the stimulus can
  // keep offering requests until the block backs up and stops taking them.
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Compares every accepted result against the oldest pending expectation.
  pedal_result_t head;
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_positions.size() == 0) begin
        report_mismatch("result with no request pending", int'(result_ch.pedal_value), 0);
      end else begin
        head = pending_positions.pop_front();
        if (result_ch.pedal_out !== head.pedal)
          report_mismatch("pedal_out", int'(result_ch.pedal_out), int'(head.pedal));
        if (result_ch.pedal_value !== head.position)
          report_mismatch("pedal_value", int'(result_ch.pedal_value), int'(head.position));
        results_checked++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still pending.", pending_positions.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int i;
    int p;
    int n;
    logic [SEL_W-1:0] sel;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.pedal_sel = '0;
    sample_ch.sample_mv = '0;
    result_ch.ready     = 1'b0;
    for (i = 0; i < NUM_PEDALS; i++) begin
      cal_lo_mv[i] = LOW_RESET;
      cal_hi_mv[i] = HIGH_RESET;
      avg_q88[i]   = '0;
      last_pos[i]  = '0;
      glide_mv[i]  = 2000;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: rails, the unused pedal code, full-scale, inverted,
    // empty and very narrow ranges, and writes to the unmapped indexes.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(CFG_IDX_W'(directed_rows[i].code), MV_W'(directed_rows[i].value));
      end else begin
        send_request(SEL_W'(directed_rows[i].code), MV_W'(directed_rows[i].value),
                     directed_rows[i].want);
      end
    end

    // Random phases, each under its own calibration. One phase runs with no
    // idling on either side; another opens with a long receiver hold-off.
    for (p = 0; p < PHASES; p++) begin
      settle();
      program_calibration(p);
      idle_on = (p != 2);
      if (p == 4)
        hold_request = 1'b1;
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        sel = ($urandom_range(0, 19) == 0) ? PEDAL_NONE
                                           : SEL_W'($urandom_range(0, NUM_PEDALS - 1));
        send_request(sel, pick_sample(sel), NO_CHECK);
      end
    end

    settle();
    $display("Sent %0d requests (directed table plus %0d random calibration phases).",
             requests_sent, PHASES);
    $display("Checked %0d results under idle, back-to-back and held-off traffic; %0d errors.",
             results_checked, error_count);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
